// ----- src/tlf_pkg.sv -----
// Shared types, constants and helper functions for the tire longitudinal force core.
`timescale 1ns / 1ps
package tlf_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int ACW = 48;
    localparam int ZW = 34;
    localparam int SW = 35;
    localparam int RW = 49;
    localparam int RED_STEPS = 15;
    localparam int DIV_BITS = 31;

    localparam logic [RW-1:0] TWO_PI_Q30 = 49'd6746518852;
    localparam logic [RW-1:0] PHASE_BIAS = TWO_PI_Q30 << 14;
    localparam logic signed [SW-1:0] TWO_PI_S = 35'sd6746518852;
    localparam logic signed [SW-1:0] PI_Q30 = 35'sd3373259426;
    localparam logic signed [SW-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [SW-1:0] INV_GAIN_Q30 = 35'sd652032874;

    typedef enum logic [2:0] {
        REG_HSHIFT  = 3'd0,
        REG_VSHIFT  = 3'd1,
        REG_FPEAK   = 3'd2,
        REG_FCAMBER = 3'd3,
        REG_SHAPE   = 3'd4,
        REG_CURV    = 3'd5,
        REG_STIFF   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [37:0] d8;
        logic signed [37:0] sv8;
        logic               degen;
    } tail_t;

    typedef struct packed {
        logic signed [31:0] kx;
        tail_t              tail;
    } div_side_t;

    typedef struct packed {
        logic signed [31:0] bx;
        tail_t              tail;
    } atan_side_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // atan(2^-i) in Q.30, rounded to nearest
    function automatic logic signed [31:0] cordic_angle(input int i);
        logic signed [31:0] a;
        case (i)
            0: a = 32'sd843314857;
            1: a = 32'sd497837829;
            2: a = 32'sd263043837;
            3: a = 32'sd133525159;
            4: a = 32'sd67021687;
            5: a = 32'sd33543516;
            6: a = 32'sd16775851;
            7: a = 32'sd8388437;
            8: a = 32'sd4194283;
            9: a = 32'sd2097149;
            default:
            begin
                if (i < 31)
                begin
                    a = 32'sd1 <<< (30 - i);
                end
                else if (i == 31)
                begin
                    a = 32'sd1;
                end
                else
                begin
                    a = '0;
                end
            end
        endcase
        return a;
    endfunction

endpackage

// ----- src/tlf_front.sv -----
// Front pipeline: slip offset, camber friction drop, peak friction, C*mu and load terms.
`timescale 1ns / 1ps
module tlf_front
    import tlf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [15:0] slip_ratio,
    input  logic signed [15:0] camber_angle,
    input  logic        [15:0] normal_load,
    input  logic signed [31:0] horizontal_shift,
    input  logic signed [31:0] vertical_shift_per_load,
    input  logic signed [31:0] friction_peak,
    input  logic signed [31:0] friction_camber_drop,
    input  logic signed [31:0] shape_factor,
    output logic               out_valid,
    output logic signed [63:0] out_cm,
    output div_side_t          out_side
);

    logic [5:0] vld_reg;

    logic signed [31:0] s1_kx_reg, s2_kx_reg, s3_kx_reg, s4_kx_reg, s5_kx_reg;
    logic signed [37:0] s1_sv8_reg, s2_sv8_reg, s3_sv8_reg, s4_sv8_reg, s5_sv8_reg;
    logic        [15:0] s1_load_reg, s2_load_reg, s3_load_reg, s4_load_reg, s5_load_reg;
    logic signed [31:0] s1_gg_reg;
    logic signed [63:0] s2_tprod_reg;
    logic signed [31:0] s3_om_reg;
    logic signed [63:0] s4_muprod_reg;
    logic signed [31:0] s5_mu_reg;
    logic               s5_degen_reg;
    logic signed [63:0] cm_reg;
    div_side_t          side_reg;

    logic signed [33:0] kx_sum;
    logic signed [48:0] sv_prod;
    logic signed [31:0] mu_next;
    logic signed [48:0] d8_prod;

    assign kx_sum  = 34'(horizontal_shift) - (34'(slip_ratio) <<< 4);
    assign sv_prod = 49'(vertical_shift_per_load) * 49'($signed({1'b0, normal_load}));
    assign mu_next = sat32(s4_muprod_reg >>> 16);
    assign d8_prod = 49'(s5_mu_reg) * 49'($signed({1'b0, s5_load_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kx_reg   <= sat32(64'(kx_sum));
        s1_gg_reg   <= 32'(camber_angle) * 32'(camber_angle);
        s1_sv8_reg  <= 38'(sv_prod >>> 10);
        s1_load_reg <= normal_load;

        s2_tprod_reg <= 64'(friction_camber_drop) * 64'(s1_gg_reg);
        s2_kx_reg    <= s1_kx_reg;
        s2_sv8_reg   <= s1_sv8_reg;
        s2_load_reg  <= s1_load_reg;

        s3_om_reg   <= sat32(64'sd65536 - (s2_tprod_reg >>> 24));
        s3_kx_reg   <= s2_kx_reg;
        s3_sv8_reg  <= s2_sv8_reg;
        s3_load_reg <= s2_load_reg;

        s4_muprod_reg <= 64'(friction_peak) * 64'(s3_om_reg);
        s4_kx_reg     <= s3_kx_reg;
        s4_sv8_reg    <= s3_sv8_reg;
        s4_load_reg   <= s3_load_reg;

        s5_mu_reg    <= mu_next;
        s5_degen_reg <= (shape_factor == '0) || (mu_next == '0) || (s4_load_reg == '0);
        s5_kx_reg    <= s4_kx_reg;
        s5_sv8_reg   <= s4_sv8_reg;
        s5_load_reg  <= s4_load_reg;

        cm_reg              <= 64'(shape_factor) * 64'(s5_mu_reg);
        side_reg.kx         <= s5_kx_reg;
        side_reg.tail.d8    <= 38'(d8_prod >>> 10);
        side_reg.tail.sv8   <= s5_sv8_reg;
        side_reg.tail.degen <= s5_degen_reg;
    end

    assign out_valid = vld_reg[5];
    assign out_cm    = cm_reg;
    assign out_side  = side_reg;

endmodule

// ----- src/tlf_div.sv -----
// Pipelined restoring divider: saturated B = stiffness / (C*mu), one quotient bit per stage.
`timescale 1ns / 1ps
module tlf_div
    import tlf_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [63:0] in_cm,
    input  logic signed [31:0] stiffness,
    input  logic [SIDE_W-1:0]  in_side,
    output logic               out_valid,
    output logic signed [31:0] out_b,
    output logic [SIDE_W-1:0]  out_side
);

    logic                vld_reg  [0:DIV_BITS];
    logic [63:0]         rem_reg  [0:DIV_BITS];
    logic [DIV_BITS-1:0] q_reg    [0:DIV_BITS];
    logic [62:0]         den_reg  [0:DIV_BITS];
    logic                sat_reg  [0:DIV_BITS];
    logic                neg_reg  [0:DIV_BITS];
    logic [SIDE_W-1:0]   side_reg [0:DIV_BITS];

    logic               fin_vld_reg;
    logic signed [31:0] fin_b_reg;
    logic [SIDE_W-1:0]  fin_side_reg;

    logic [32:0] kabs;
    logic [62:0] cmabs;
    logic [63:0] rem0;
    logic signed [31:0] qs;

    assign kabs  = stiffness[31] ? 33'(-(33'(stiffness))) : 33'(stiffness);
    assign cmabs = in_cm[63] ? 63'(-in_cm) : 63'(in_cm);
    assign rem0  = 64'({kabs, 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= rem0;
        q_reg[0]    <= '0;
        den_reg[0]  <= cmabs;
        sat_reg[0]  <= rem0 >= 64'(cmabs);
        neg_reg[0]  <= stiffness[31] ^ in_cm[63];
        side_reg[0] <= in_side;
    end

    for (genvar j = 1; j <= DIV_BITS; j++)
    begin : g_stage
        logic [63:0] r2;
        logic        ge;

        assign r2 = rem_reg[j-1] << 1;
        assign ge = r2 >= 64'(den_reg[j-1]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= ge ? (r2 - 64'(den_reg[j-1])) : r2;
            q_reg[j]    <= {q_reg[j-1][DIV_BITS-2:0], ge};
            den_reg[j]  <= den_reg[j-1];
            sat_reg[j]  <= sat_reg[j-1];
            neg_reg[j]  <= neg_reg[j-1];
            side_reg[j] <= side_reg[j-1];
        end
    end

    assign qs = $signed({1'b0, q_reg[DIV_BITS]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_vld_reg <= 1'b0;
        end
        else
        begin
            fin_vld_reg <= vld_reg[DIV_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sat_reg[DIV_BITS])
        begin
            fin_b_reg <= neg_reg[DIV_BITS] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else
        begin
            fin_b_reg <= neg_reg[DIV_BITS] ? -qs : qs;
        end
        fin_side_reg <= side_reg[DIV_BITS];
    end

    assign out_valid = fin_vld_reg;
    assign out_b     = fin_b_reg;
    assign out_side  = fin_side_reg;

endmodule

// ----- src/tlf_atan.sv -----
// Pipelined vectoring CORDIC: arctangent of a Q16.16 value, angle out in Q.30.
`timescale 1ns / 1ps
module tlf_atan
    import tlf_pkg::*;
#(
    parameter int STEPS  = CORDIC_STEPS_DEF,
    parameter int SIDE_W = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [31:0]   in_x,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic signed [ZW-1:0] out_z,
    output logic [SIDE_W-1:0]    out_side
);

    logic                  vld_reg  [0:STEPS];
    logic signed [ACW-1:0] cx_reg   [0:STEPS];
    logic signed [ACW-1:0] cy_reg   [0:STEPS];
    logic signed [ZW-1:0]  z_reg    [0:STEPS];
    logic [SIDE_W-1:0]     side_reg [0:STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg[0]   <= ACW'(64'sd1 <<< 30);
        cy_reg[0]   <= ACW'(in_x) <<< 14;
        z_reg[0]    <= '0;
        side_reg[0] <= in_side;
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] ANG = ZW'(cordic_angle(i));
        logic signed [ACW-1:0] dx;
        logic signed [ACW-1:0] dy;

        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (!cy_reg[i][ACW-1])
            begin
                cx_reg[i+1] <= cx_reg[i] + dx;
                cy_reg[i+1] <= cy_reg[i] - dy;
                z_reg[i+1]  <= z_reg[i] + ANG;
            end
            else
            begin
                cx_reg[i+1] <= cx_reg[i] - dx;
                cy_reg[i+1] <= cy_reg[i] + dy;
                z_reg[i+1]  <= z_reg[i] - ANG;
            end
            side_reg[i+1] <= side_reg[i];
        end
    end

    assign out_valid = vld_reg[STEPS];
    assign out_z     = z_reg[STEPS];
    assign out_side  = side_reg[STEPS];

endmodule

// ----- src/tlf_sin.sv -----
// Sine pipeline: modulo 2*pi reduction, quadrant fold and rotation CORDIC in Q.30.
`timescale 1ns / 1ps
module tlf_sin
    import tlf_pkg::*;
#(
    parameter int STEPS  = CORDIC_STEPS_DEF,
    parameter int SIDE_W = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [RW-1:0]        in_phase,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic signed [SW-1:0] out_sin,
    output logic [SIDE_W-1:0]    out_side
);

    logic              rvld_reg  [0:RED_STEPS];
    logic [RW-1:0]     red_reg   [0:RED_STEPS];
    logic [SIDE_W-1:0] rside_reg [0:RED_STEPS];

    logic                 vld_reg  [0:STEPS];
    logic signed [SW-1:0] cx_reg   [0:STEPS];
    logic signed [SW-1:0] cy_reg   [0:STEPS];
    logic signed [SW-1:0] ang_reg  [0:STEPS];
    logic [SIDE_W-1:0]    side_reg [0:STEPS];

    logic signed [SW-1:0] r_w;
    logic signed [SW-1:0] r_h;
    logic signed [SW-1:0] r_f;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvld_reg[0] <= 1'b0;
        end
        else
        begin
            rvld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg[0]   <= in_phase;
        rside_reg[0] <= in_side;
    end

    for (genvar k = 1; k <= RED_STEPS; k++)
    begin : g_red
        localparam logic [RW-1:0] SUB = TWO_PI_Q30 << (RED_STEPS - k);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rvld_reg[k] <= 1'b0;
            end
            else
            begin
                rvld_reg[k] <= rvld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            red_reg[k]   <= (red_reg[k-1] >= SUB) ? (red_reg[k-1] - SUB) : red_reg[k-1];
            rside_reg[k] <= rside_reg[k-1];
        end
    end

    // wrap to (-pi, pi], then fold into [-pi/2, pi/2]
    assign r_w = $signed(SW'(red_reg[RED_STEPS]));
    assign r_h = (r_w > PI_Q30) ? (r_w - TWO_PI_S) : r_w;

    always_comb
    begin
        if (r_h > HALF_PI_Q30)
        begin
            r_f = PI_Q30 - r_h;
        end
        else if (r_h < -HALF_PI_Q30)
        begin
            r_f = -PI_Q30 - r_h;
        end
        else
        begin
            r_f = r_h;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= rvld_reg[RED_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg[0]   <= INV_GAIN_Q30;
        cy_reg[0]   <= '0;
        ang_reg[0]  <= r_f;
        side_reg[0] <= rside_reg[RED_STEPS];
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_rot
        localparam logic signed [SW-1:0] ANG = SW'(cordic_angle(i));
        logic signed [SW-1:0] dx;
        logic signed [SW-1:0] dy;

        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (!ang_reg[i][SW-1])
            begin
                cx_reg[i+1]  <= cx_reg[i] - dx;
                cy_reg[i+1]  <= cy_reg[i] + dy;
                ang_reg[i+1] <= ang_reg[i] - ANG;
            end
            else
            begin
                cx_reg[i+1]  <= cx_reg[i] + dx;
                cy_reg[i+1]  <= cy_reg[i] - dy;
                ang_reg[i+1] <= ang_reg[i] + ANG;
            end
            side_reg[i+1] <= side_reg[i];
        end
    end

    assign out_valid = vld_reg[STEPS];
    assign out_sin   = cy_reg[STEPS];
    assign out_side  = side_reg[STEPS];

endmodule

// ----- src/tire_longitudinal_force_core.sv -----
// Top level: pure-slip longitudinal tire force, magic formula, fully pipelined.
//
//  channel  | signals                                          | transfer
//  ---------+--------------------------------------------------+------------------------------
//  command  | start, busy, slip_ratio, camber_angle,           | start high, busy low
//           | normal_load                                      |
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data        | cfg_valid and cfg_ready high
//  result   | result_valid, longitudinal_force, degenerate     | result_valid high, one cycle
//
// One item enters every cycle; busy stays low. The path runs through the front stages, the
// 31-bit divider, two arctangent CORDICs, the phase reduction and the sine CORDIC in series.
// Reset clears the valid bits and the coefficient registers.
// The result side has no backpressure, so nothing in the pipeline ever stalls.
`timescale 1ns / 1ps
module tire_longitudinal_force_core
    import tlf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] slip_ratio,
    input  logic signed [15:0] camber_angle,
    input  logic        [15:0] normal_load,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [2:0]  cfg_index,
    input  logic        [31:0] cfg_data,
    output logic               result_valid,
    output logic signed [31:0] longitudinal_force,
    output logic               degenerate
);

    logic signed [31:0] hshift_reg, vshift_reg, fpeak_reg, fcamber_reg;
    logic signed [31:0] shape_reg, curv_reg, stiff_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hshift_reg  <= '0;
            vshift_reg  <= '0;
            fpeak_reg   <= '0;
            fcamber_reg <= '0;
            shape_reg   <= '0;
            curv_reg    <= '0;
            stiff_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_HSHIFT:  hshift_reg  <= $signed(cfg_data);
                REG_VSHIFT:  vshift_reg  <= $signed(cfg_data);
                REG_FPEAK:   fpeak_reg   <= $signed(cfg_data);
                REG_FCAMBER: fcamber_reg <= $signed(cfg_data);
                REG_SHAPE:   shape_reg   <= $signed(cfg_data);
                REG_CURV:    curv_reg    <= $signed(cfg_data);
                REG_STIFF:   stiff_reg   <= $signed(cfg_data);
                default:     ;
            endcase
        end
    end

    // front end
    logic               fr_valid;
    logic signed [63:0] fr_cm;
    div_side_t          fr_side;

    tlf_front u_front (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .in_valid                (start),
        .slip_ratio              (slip_ratio),
        .camber_angle            (camber_angle),
        .normal_load             (normal_load),
        .horizontal_shift        (hshift_reg),
        .vertical_shift_per_load (vshift_reg),
        .friction_peak           (fpeak_reg),
        .friction_camber_drop    (fcamber_reg),
        .shape_factor            (shape_reg),
        .out_valid               (fr_valid),
        .out_cm                  (fr_cm),
        .out_side                (fr_side)
    );

    // stiffness B
    localparam int DSW = $bits(div_side_t);
    logic               dv_valid;
    logic signed [31:0] dv_b;
    logic [DSW-1:0]     dv_side_vec;
    div_side_t          dv_side;

    tlf_div #(
        .SIDE_W (DSW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_cm     (fr_cm),
        .stiffness (stiff_reg),
        .in_side   (fr_side),
        .out_valid (dv_valid),
        .out_b     (dv_b),
        .out_side  (dv_side_vec)
    );

    assign dv_side = dv_side_vec;

    // B*kx
    logic               m1_vld_reg, m2_vld_reg;
    logic signed [63:0] m1_prod_reg;
    tail_t              m1_tail_reg, m2_tail_reg;
    logic signed [31:0] m2_bx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
        end
        else
        begin
            m1_vld_reg <= dv_valid;
            m2_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_prod_reg <= 64'(dv_b) * 64'(dv_side.kx);
        m1_tail_reg <= dv_side.tail;
        m2_bx_reg   <= sat32(m1_prod_reg >>> 16);
        m2_tail_reg <= m1_tail_reg;
    end

    // first arctangent
    localparam int ASW = $bits(atan_side_t);
    atan_side_t           a1_side_in;
    logic                 a1_valid;
    logic signed [ZW-1:0] a1_z;
    logic [ASW-1:0]       a1_side_vec;
    atan_side_t           a1_side;

    assign a1_side_in.bx   = m2_bx_reg;
    assign a1_side_in.tail = m2_tail_reg;

    tlf_atan #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W (ASW)
    ) u_atan_bx (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m2_vld_reg),
        .in_x      (m2_bx_reg),
        .in_side   (a1_side_in),
        .out_valid (a1_valid),
        .out_z     (a1_z),
        .out_side  (a1_side_vec)
    );

    assign a1_side = a1_side_vec;

    // curvature term
    logic               m3_vld_reg, m4_vld_reg, m5_vld_reg;
    logic signed [31:0] m3_diff_reg, m3_bx_reg, m4_bx_reg, m5_u_reg;
    logic signed [63:0] m4_prod_reg;
    tail_t              m3_tail_reg, m4_tail_reg, m5_tail_reg;
    logic signed [ZW-1:0] a1_at;
    logic signed [31:0] ed;

    assign a1_at = a1_z >>> 14;
    assign ed    = sat32(m4_prod_reg >>> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m3_vld_reg <= 1'b0;
            m4_vld_reg <= 1'b0;
            m5_vld_reg <= 1'b0;
        end
        else
        begin
            m3_vld_reg <= a1_valid;
            m4_vld_reg <= m3_vld_reg;
            m5_vld_reg <= m4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m3_diff_reg <= sat32(64'(a1_side.bx) - 64'(a1_at));
        m3_bx_reg   <= a1_side.bx;
        m3_tail_reg <= a1_side.tail;
        m4_prod_reg <= 64'(curv_reg) * 64'(m3_diff_reg);
        m4_bx_reg   <= m3_bx_reg;
        m4_tail_reg <= m3_tail_reg;
        m5_u_reg    <= sat32(64'(m4_bx_reg) - 64'(ed));
        m5_tail_reg <= m4_tail_reg;
    end

    // second arctangent
    localparam int TSW = $bits(tail_t);
    logic                 a2_valid;
    logic signed [ZW-1:0] a2_z;
    logic [TSW-1:0]       a2_side_vec;
    tail_t                a2_tail;

    tlf_atan #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W (TSW)
    ) u_atan_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m5_vld_reg),
        .in_x      (m5_u_reg),
        .in_side   (m5_tail_reg),
        .out_valid (a2_valid),
        .out_z     (a2_z),
        .out_side  (a2_side_vec)
    );

    assign a2_tail = a2_side_vec;

    // phase C*atan(.)
    logic               m6_vld_reg, m7_vld_reg;
    logic signed [63:0] m6_prod_reg;
    tail_t              m6_tail_reg, m7_tail_reg;
    logic [RW-1:0]      m7_phase_reg;
    logic signed [ZW-1:0] a2_v;
    logic signed [RW:0] ph_x;

    assign a2_v = a2_z >>> 14;
    assign ph_x = (RW+1)'((m6_prod_reg >>> 16) <<< 14);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m6_vld_reg <= 1'b0;
            m7_vld_reg <= 1'b0;
        end
        else
        begin
            m6_vld_reg <= a2_valid;
            m7_vld_reg <= m6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m6_prod_reg  <= 64'(shape_reg) * 64'(a2_v);
        m6_tail_reg  <= a2_tail;
        m7_phase_reg <= RW'(ph_x + $signed({1'b0, PHASE_BIAS}));
        m7_tail_reg  <= m6_tail_reg;
    end

    // sine
    logic                 sn_valid;
    logic signed [SW-1:0] sn_cy;
    logic [TSW-1:0]       sn_side_vec;
    tail_t                sn_tail;

    tlf_sin #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W (TSW)
    ) u_sin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m7_vld_reg),
        .in_phase  (m7_phase_reg),
        .in_side   (m7_tail_reg),
        .out_valid (sn_valid),
        .out_sin   (sn_cy),
        .out_side  (sn_side_vec)
    );

    assign sn_tail = sn_side_vec;

    // D*sin + vertical shift
    logic               m8_vld_reg, out_vld_reg;
    logic signed [63:0] m8_prod_reg;
    tail_t              m8_tail_reg;
    logic signed [31:0] force_reg;
    logic               degen_reg;
    logic signed [SW-1:0] sin_q24;

    assign sin_q24 = sn_cy >>> 6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m8_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            m8_vld_reg  <= sn_valid;
            out_vld_reg <= m8_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m8_prod_reg <= 64'(sn_tail.d8) * 64'(sin_q24);
        m8_tail_reg <= sn_tail;
        if (m8_tail_reg.degen)
        begin
            force_reg <= '0;
        end
        else
        begin
            force_reg <= sat32((m8_prod_reg >>> 24) + 64'(m8_tail_reg.sv8));
        end
        degen_reg <= m8_tail_reg.degen;
    end

    assign result_valid       = out_vld_reg;
    assign longitudinal_force = force_reg;
    assign degenerate         = degen_reg;

endmodule

// ----- dv/tlf_force_checker.sv -----
// Checker for the tire longitudinal force core: predicts each result and compares it.
`timescale 1ns / 1ps
module tlf_force_checker
    import tlf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] slip_ratio,
    input  logic signed [15:0] camber_angle,
    input  logic        [15:0] normal_load,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic        [2:0]  cfg_index,
    input  logic        [31:0] cfg_data,
    input  logic               result_valid,
    input  logic signed [31:0] longitudinal_force,
    input  logic               degenerate,
    output int                 errors,
    output int                 pending
);

    localparam int    STEPS     = 24;
    localparam longint TWO_PI   = 64'sd6746518852;
    localparam longint PI       = 64'sd3373259426;
    localparam longint HALF_PI  = 64'sd1686629713;
    localparam longint GAIN_INV = 64'sd652032874;

    typedef struct {
        logic signed [31:0] force_val;
        logic               degen;
    } force_t;

    force_t force_q[$];
    longint arc_tab[STEPS];
    longint hshift, vshift, fpeak, fcamber, shape, curv, stiff;

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint arc_series(input int i);
        longint sum;
        longint term;
        int e;
        sum = 0;
        if (i == 0)
            return 64'sd843314857;
        for (int k = 0; k < 64; k++)
        begin
            e = i * (2 * k + 1);
            if (e > 60)
                break;
            term = (64'sd1 <<< (60 - e)) / longint'(2 * k + 1);
            sum = (k % 2 == 1) ? sum - term : sum + term;
        end
        return (sum + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint arctan16(input longint x);
        longint cx, cy, z, dx, dy;
        cx = 64'sd1 <<< 30;
        cy = x * 16384;
        z = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx += dx; cy -= dy; z += arc_tab[i];
            end
            else
            begin
                cx -= dx; cy += dy; z -= arc_tab[i];
            end
        end
        return z >>> 14;
    endfunction

    function automatic longint sine24(input longint ph);
        longint r, cx, cy, dx, dy;
        r = (ph * 16384) % TWO_PI;
        cx = GAIN_INV;
        cy = 0;
        if (r < 0)
            r += TWO_PI;
        if (r > PI)
            r -= TWO_PI;
        if (r > HALF_PI)
            r = PI - r;
        else if (r < -HALF_PI)
            r = -PI - r;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (r >= 0)
            begin
                cx -= dx; cy += dy; r -= arc_tab[i];
            end
            else
            begin
                cx += dx; cy -= dy; r += arc_tab[i];
            end
        end
        return cy >>> 6;
    endfunction

    function automatic force_t tire_force(input logic signed [15:0] s16,
                                          input logic signed [15:0] c16,
                                          input logic [15:0] ld);
        force_t o;
        longint s, g, load, kx, t, om, mu, cm, b, bx, at, diff, ed, u, v, ph, d8, sv8;
        longint unsigned num, den, q;
        bit neg;
        s = s16;
        g = c16;
        load = longint'(ld);
        kx = clip32(-s * 16 + hshift);
        t = (fcamber * (g * g)) >>> 24;
        om = clip32(65536 - t);
        mu = clip32((fpeak * om) >>> 16);
        o.force_val = '0;
        o.degen = 1'b1;
        if (shape == 0 || mu == 0 || load == 0)
            return o;
        cm = shape * mu;
        num = longint'(stiff < 0 ? -stiff : stiff);
        num = num << 32;
        den = longint'(cm < 0 ? -cm : cm);
        q = num / den;
        neg = (stiff < 0) != (cm < 0);
        if (neg)
            b = (q >= 64'h80000000) ? -64'sd2147483648 : -longint'(q);
        else
            b = (q > 64'h7FFFFFFF) ? 64'sd2147483647 : longint'(q);
        bx = clip32((b * kx) >>> 16);
        at = arctan16(bx);
        diff = clip32(bx - at);
        ed = clip32((curv * diff) >>> 16);
        u = clip32(bx - ed);
        v = arctan16(u);
        ph = (shape * v) >>> 16;
        d8 = (mu * load) >>> 10;
        sv8 = (vshift * load) >>> 10;
        o.force_val = clip32(((d8 * sine24(ph)) >>> 24) + sv8);
        o.degen = 1'b0;
        return o;
    endfunction

    initial
    begin
        for (int i = 0; i < STEPS; i++)
            arc_tab[i] = arc_series(i);
    end

    assign pending = force_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        force_t exp_f;
        if (!rst_n)
        begin
            force_q.delete();
            errors <= 0;
            hshift = 0; vshift = 0; fpeak = 0; fcamber = 0;
            shape = 0; curv = 0; stiff = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (force_q.size() == 0)
                begin
                    $display("%0t: unexpected result force=%0d degenerate=%0b",
                             $time, longitudinal_force, degenerate);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_f = force_q.pop_front();
                    if (exp_f.force_val !== longitudinal_force || exp_f.degen !== degenerate)
                    begin
                        $display("%0t: mismatch expected force=%0d degenerate=%0b",
                                 $time, exp_f.force_val, exp_f.degen,
                                 ", actual force=%0d degenerate=%0b",
                                 longitudinal_force, degenerate);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
                force_q.push_back(tire_force(slip_ratio, camber_angle, normal_load));
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_HSHIFT:  hshift  = longint'($signed(cfg_data));
                    REG_VSHIFT:  vshift  = longint'($signed(cfg_data));
                    REG_FPEAK:   fpeak   = longint'($signed(cfg_data));
                    REG_FCAMBER: fcamber = longint'($signed(cfg_data));
                    REG_SHAPE:   shape   = longint'($signed(cfg_data));
                    REG_CURV:    curv    = longint'($signed(cfg_data));
                    REG_STIFF:   stiff   = longint'($signed(cfg_data));
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- dv/tb_tire_longitudinal_force_core.sv -----
// Testbench top: drives commands and coefficient writes, gives the verdict.
`timescale 1ns / 1ps
module tb_tire_longitudinal_force_core;
    import tlf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 300;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] slip_ratio = '0;
    logic signed [15:0] camber_angle = '0;
    logic        [15:0] normal_load = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic        [2:0]  cfg_index = '0;
    logic        [31:0] cfg_data = '0;
    logic               result_valid;
    logic signed [31:0] longitudinal_force;
    logic               degenerate;
    int                 errors;
    int                 pending;
    int                 cycles = 0;

    always #1 clk = ~clk;

    tire_longitudinal_force_core dut (.*);

    tlf_force_checker u_checker (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_tire(input logic [15:0] s, input logic [15:0] c, input logic [15:0] l);
        start <= 1'b1;
        slip_ratio <= s;
        camber_angle <= c;
        normal_load <= l;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_coef(input reg_idx_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic load_coefs(input logic [31:0] hs, input logic [31:0] vs,
                              input logic [31:0] fp, input logic [31:0] fc,
                              input logic [31:0] sh, input logic [31:0] cv,
                              input logic [31:0] st);
        wait_drained();
        write_coef(REG_HSHIFT, hs);
        write_coef(REG_VSHIFT, vs);
        write_coef(REG_FPEAK, fp);
        write_coef(REG_FCAMBER, fc);
        write_coef(REG_SHAPE, sh);
        write_coef(REG_CURV, cv);
        write_coef(REG_STIFF, st);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_coef(input int lo, input int hi);
        case ($urandom_range(9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return '0;
            3: return $urandom;
            default: return 32'(lo + int'($urandom_range(hi - lo)));
        endcase
    endfunction

    task automatic random_tire();
        logic [15:0] s, c, l;
        s = ($urandom_range(1)) ? 16'($signed($urandom_range(2458)) - 1229) : 16'($urandom);
        c = ($urandom_range(3) != 0) ? 16'($signed($urandom_range(800)) - 400) : 16'($urandom);
        case ($urandom_range(19))
            0: l = '0;
            1: l = 16'hFFFF;
            default: l = 16'($urandom);
        endcase
        send_tire(s, c, l);
    endtask

    initial
    begin
        int n_items;
        bit quiet;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coefficients still at reset: every item degenerate
        send_tire(16'h1000, 16'h0100, 16'd4000);
        send_tire(16'h8000, 16'h7FFF, 16'hFFFF);

        load_coefs(32'h0000_0000, 32'h0000_1999, 32'h0001_3333, 32'h0000_8000,
                   32'h0001_A666, 32'hFFFF_B333, 32'h0014_0000);
        send_tire(16'h0000, 16'h0000, 16'd16000);
        send_tire(16'h7FFF, 16'h0000, 16'd16000);
        send_tire(16'h8000, 16'h0000, 16'd16000);
        send_tire(16'hFFFF, 16'h0000, 16'd16000);
        send_tire(16'h0001, 16'h0000, 16'd16000);
        send_tire(16'h0199, 16'h7FFF, 16'd16000);
        send_tire(16'hFE67, 16'h8000, 16'd16000);
        send_tire(16'h0199, 16'h0100, 16'h0000);
        send_tire(16'h0199, 16'h0100, 16'h0001);
        send_tire(16'h0199, 16'h0100, 16'hFFFF);
        send_tire(16'h0080, 16'h0010, 16'd8000);
        send_tire(16'hFF80, 16'hFFF0, 16'd8000);
        send_tire(16'h2000, 16'h0000, 16'd8000);
        send_tire(16'hE000, 16'h0000, 16'd8000);
        // friction driven negative by camber drop
        load_coefs(32'h0000_0000, 32'h0000_1999, 32'h0001_0000, 32'h0100_0000,
                   32'h0001_A666, 32'h0000_0000, 32'h0014_0000);
        send_tire(16'h0100, 16'h1000, 16'd8000);
        send_tire(16'h0100, 16'h0000, 16'd8000);
        // huge shape: large phase folding, saturation
        load_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_tire(16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_tire(16'h8000, 16'h8000, 16'hFFFF);
        load_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_tire(16'h7FFF, 16'h0000, 16'hFFFF);
        send_tire(16'h8000, 16'h0001, 16'hFFFF);

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 0)
                load_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            else if (ph == 1)
                load_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            else
                load_coefs(pick_coef(-6554, 6554), pick_coef(-13107, 13107),
                           pick_coef(45875, 98304), pick_coef(0, 65536),
                           pick_coef(78643, 131072), pick_coef(-65536, 65536),
                           pick_coef(327680, 2621440));
            n_items = (ph < 2) ? 60 : 140;
            quiet = (ph == 7);
            for (int i = 0; i < n_items; i++)
            begin
                if (!quiet && $urandom_range(7) == 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 16)) @(posedge clk);
                end
                random_tire();
            end
        end
        start <= 1'b0;

        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/tlf_pkg.sv
src/tlf_front.sv
src/tlf_div.sv
src/tlf_atan.sv
src/tlf_sin.sv
src/tire_longitudinal_force_core.sv
dv/tlf_force_checker.sv
dv/tb_tire_longitudinal_force_core.sv
